@@ rtl/core/gpsr_pkg.sv @@
// types, constants and helpers shared by the gpio port register block
`default_nettype none

package gpsr_pkg;

    localparam int unsigned DEF_WORD_COUNT  = 13;
    localparam int unsigned REGISTER_WINDOW = 1024;

    localparam int unsigned W_MODE   = 0;
    localparam int unsigned W_TYPE   = 1;
    localparam int unsigned W_SPEED  = 2;
    localparam int unsigned W_PULL   = 3;
    localparam int unsigned W_IN     = 4;
    localparam int unsigned W_OUT    = 5;
    localparam int unsigned W_SETRST = 6;
    localparam int unsigned W_LOCK   = 7;
    localparam int unsigned W_AFL    = 8;
    localparam int unsigned W_AFH    = 9;
    localparam int unsigned W_RST    = 10;
    localparam int unsigned W_LEVEL  = 11;
    localparam int unsigned W_SEC    = 12;

    localparam logic [11:0] OFF_MODE   = 12'(W_MODE * 4);
    localparam logic [11:0] OFF_TYPE   = 12'(W_TYPE * 4);
    localparam logic [11:0] OFF_SPEED  = 12'(W_SPEED * 4);
    localparam logic [11:0] OFF_PULL   = 12'(W_PULL * 4);
    localparam logic [11:0] OFF_IN     = 12'(W_IN * 4);
    localparam logic [11:0] OFF_OUT    = 12'(W_OUT * 4);
    localparam logic [11:0] OFF_SETRST = 12'(W_SETRST * 4);
    localparam logic [11:0] OFF_LOCK   = 12'(W_LOCK * 4);
    localparam logic [11:0] OFF_AFL    = 12'(W_AFL * 4);
    localparam logic [11:0] OFF_AFH    = 12'(W_AFH * 4);
    localparam logic [11:0] OFF_RST    = 12'(W_RST * 4);
    localparam logic [11:0] OFF_LEVEL  = 12'(W_LEVEL * 4);
    localparam logic [11:0] OFF_SEC    = 12'(W_SEC * 4);

    localparam logic [31:0] MODE_RST_PORT0 = 32'hABFF_FFFF;
    localparam logic [31:0] MODE_RST_OTHER = 32'hFFFF_FFFF;
    localparam logic [15:0] ALL_PINS       = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_REINIT = 2'd2
    } t_op;

    localparam logic [1:0] LK_IDLE = 2'd0;
    localparam logic [1:0] LK_ONE  = 2'd1;
    localparam logic [1:0] LK_TWO  = 2'd2;
    localparam logic [1:0] LK_DONE = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [11:0] offset;
        logic [2:0]  access_size;
        logic [31:0] write_data;
        logic        secure;
        logic        clock_on;
        logic [3:0]  pin;
    } t_in_beat;

    typedef struct packed {
        logic        rejected;
        logic [31:0] read_data;
        logic        odr_changed;
        logic [31:0] old_output;
        logic [31:0] new_output;
        logic [3:0]  event_bank;
        logic [1:0]  pin_mode;
        logic [3:0]  pin_function;
    } t_out_beat;

    typedef struct packed {
        logic [1:0] progress;
        logic       engaged;
    } t_lock_state;

    function automatic logic [31:0] mode_reset(input logic [3:0] bank);
        return (bank == 4'd0) ? MODE_RST_PORT0 : MODE_RST_OTHER;
    endfunction

    function automatic logic [31:0] widen_pairs(input logic [15:0] pins);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            r[2*i +: 2] = {2{pins[i]}};
        end
        return r;
    endfunction

    function automatic logic [31:0] nibble_mask(input logic [7:0] pins);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            r[4*i +: 4] = {4{pins[i]}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/gpsr_access.sv @@
// one register access: decode, secure masking, read-modify-write and pin report
`default_nettype none

module gpsr_access
    import gpsr_pkg::*;
#(
    parameter int unsigned WORD_COUNT = DEF_WORD_COUNT
) (
    input  var t_in_beat                         i_item,
    input  var logic [WORD_COUNT-1:0][31:0]      i_regs,
    input  var t_lock_state                      i_lock,
    input  var logic [3:0]                       i_bank,
    output var logic [WORD_COUNT-1:0][31:0]      o_regs,
    output var t_lock_state                      o_lock,
    output var t_out_beat                        o_result
);

    localparam int unsigned IDX_W = $clog2(WORD_COUNT);
    localparam logic [12:0] BYTE_LIMIT = 13'(WORD_COUNT * 4);

    logic        size_ok;
    logic        rej;
    logic        do_rd;
    logic        do_wr;
    logic [11:0] off;
    logic [31:0] wdata;
    logic        sec;
    logic [31:0] open_pins;
    logic [31:0] pair_mask;
    logic [15:0] wr_pins;
    logic [31:0] rd_raw;
    logic [31:0] rd_val;
    logic [31:0] old_out;
    logic [31:0] new_out;
    logic        out_hit;
    logic        chg;
    logic [31:0] m;
    logic [31:0] o;
    logic [12:0] a;
    logic        key;

    assign off       = i_item.offset;
    assign wdata     = i_item.write_data;
    assign sec       = i_item.secure;
    assign open_pins = ~i_regs[W_SEC];
    assign pair_mask = widen_pairs(open_pins[15:0]);
    assign wr_pins   = sec ? ALL_PINS : open_pins[15:0];
    assign old_out   = i_regs[W_OUT];

    assign size_ok = (i_item.access_size != 3'd0) && (i_item.access_size <= 3'd4);
    assign rej     = (i_item.operation != OP_REINIT)
                   && ((i_item.operation != OP_READ && i_item.operation != OP_WRITE)
                       || !size_ok || ({1'b0, off} >= 13'(REGISTER_WINDOW)));
    assign do_rd   = !rej && i_item.clock_on && (i_item.operation == OP_READ);
    assign do_wr   = !rej && i_item.clock_on && (i_item.operation == OP_WRITE);

    // little-endian byte gather, bytes past the words read as zero
    always_comb begin
        rd_raw = '0;
        for (int i = 0; i < 4; i++) begin
            a = {1'b0, off} + 13'(i);
            if ((3'(i) < i_item.access_size) && (a < BYTE_LIMIT)) begin
                rd_raw[8*i +: 8] = i_regs[a[IDX_W+1:2]][{a[1:0], 3'b000} +: 8];
            end
        end
    end

    always_comb begin
        rd_val = rd_raw;
        if (!sec) begin
            if (off == OFF_SEC) begin
                rd_val = '0;
            end else if (off == OFF_IN || off == OFF_OUT || off == OFF_SETRST
                      || off == OFF_LOCK || off == OFF_AFL || off == OFF_AFH
                      || off == OFF_RST || off == OFF_LEVEL || off == OFF_TYPE) begin
                rd_val = rd_raw & open_pins;
            end else if (off == OFF_MODE || off == OFF_SPEED || off == OFF_PULL) begin
                rd_val = rd_raw & pair_mask;
            end
        end
    end

    always_comb begin
        o_regs = i_regs;
        o_lock = i_lock;
        m      = '0;
        o      = old_out;
        key    = wdata[16];
        if (i_item.operation == OP_REINIT) begin
            o_regs         = '0;
            o_regs[W_MODE] = mode_reset(i_bank);
            o_lock.engaged = 1'b0;
        end else if (do_wr) begin
            if (!sec && off == OFF_SEC) begin
                o_regs = i_regs;
            end else if (!sec && (off == OFF_AFL || off == OFF_AFH)) begin
                m = nibble_mask((off == OFF_AFL) ? open_pins[7:0] : open_pins[15:8]);
                if (off == OFF_AFL) begin
                    o_regs[W_AFL] = (i_regs[W_AFL] & ~m) | (wdata & m);
                end else begin
                    o_regs[W_AFH] = (i_regs[W_AFH] & ~m) | (wdata & m);
                end
            end else if (!sec && off == OFF_MODE) begin
                o_regs[W_MODE] = (i_regs[W_MODE] & ~pair_mask) | (wdata & pair_mask);
            end else if (!sec && off == OFF_SPEED) begin
                o_regs[W_SPEED] = (i_regs[W_SPEED] & ~pair_mask) | (wdata & pair_mask);
            end else if (!sec && off == OFF_PULL) begin
                o_regs[W_PULL] = (i_regs[W_PULL] & ~pair_mask) | (wdata & pair_mask);
            end else if (!sec && off == OFF_TYPE) begin
                o_regs[W_TYPE] = (i_regs[W_TYPE] & ~open_pins) | (wdata & open_pins);
            end else if (off == OFF_SETRST) begin
                o[15:0] = (old_out[15:0] | (wdata[15:0] & wr_pins))
                        & ~(wdata[31:16] & wr_pins);
                o_regs[W_OUT] = o;
            end else if (off == OFF_RST) begin
                o[15:0] = old_out[15:0] & ~(wdata[15:0] & wr_pins);
                o_regs[W_OUT] = o;
            end else if (off == OFF_LOCK) begin
                if (!i_lock.engaged) begin
                    if (i_lock.progress == LK_IDLE && key) begin
                        o_lock.progress = LK_ONE;
                    end else if (i_lock.progress == LK_ONE && !key) begin
                        o_lock.progress = LK_TWO;
                    end else if (i_lock.progress == LK_TWO && key) begin
                        o_lock.progress = LK_DONE;
                        o_lock.engaged  = 1'b1;
                    end else begin
                        o_lock.progress = LK_IDLE;
                    end
                    o_regs[W_LOCK] = wdata;
                end
            end else if ({1'b0, off} < BYTE_LIMIT) begin
                o_regs[off[IDX_W+1:2]] = wdata;
            end
        end
        // pin-change event mirrors the output word into the input word
        if (do_wr && out_hit && (o_regs[W_OUT] != old_out)) begin
            o_regs[W_IN] = o_regs[W_OUT];
        end
    end

    assign out_hit = (off == OFF_SETRST) || (off == OFF_RST) || (off == OFF_OUT);
    assign new_out = o_regs[W_OUT];
    assign chg     = do_wr && out_hit && (new_out != old_out);

    always_comb begin
        o_result.rejected     = rej;
        o_result.read_data    = do_rd ? rd_val : '0;
        o_result.odr_changed  = chg;
        o_result.old_output   = old_out;
        o_result.new_output   = chg ? new_out : old_out;
        o_result.event_bank   = i_bank;
        o_result.pin_mode     = o_regs[W_MODE][{i_item.pin, 1'b0} +: 2];
        o_result.pin_function = i_item.pin[3]
                              ? o_regs[W_AFH][{i_item.pin[2:0], 2'b00} +: 4]
                              : o_regs[W_AFL][{i_item.pin[2:0], 2'b00} +: 4];
    end

endmodule

`default_nettype wire

@@ rtl/core/gpio_port_secure_registers.sv @@
// top level of the gpio port register block: input stage, state and result stage
//
// channel  | direction | handshake                  | beat
// ---------+-----------+----------------------------+-----------------
// in       | in        | i_in_valid / o_in_stall    | i_in_beat
// out      | out       | o_out_valid / i_out_stall  | o_out_beat
// cfg      | in        | i_cfg_we                   | i_cfg_wdata
//
// one beat per cycle sustained while the out side does not stall; a taken beat
// goes into the input register, then through the access logic into the result register
// the register file is updated as a beat leaves the input register, so the
// next beat sees it; sync reset loads the port reset values for port 0
// a stalled result holds the input register, which then stalls the in side
`default_nettype none

module gpio_port_secure_registers
    import gpsr_pkg::*;
#(
    parameter int unsigned WORD_COUNT = DEF_WORD_COUNT
) (
    input  var logic        i_clk,
    input  var logic        i_rst_n,
    input  var logic        i_in_valid,
    input  var t_in_beat    i_in_beat,
    output var logic        o_in_stall,
    output var logic        o_out_valid,
    output var t_out_beat   o_out_beat,
    input  var logic        i_out_stall,
    input  var logic        i_cfg_we,
    input  var logic [3:0]  i_cfg_wdata
);

    logic                           r_s1_valid;
    t_in_beat                       r_s1_beat;
    logic                           r_out_valid;
    t_out_beat                      r_out_beat;
    logic [3:0]                     r_bank;
    logic [WORD_COUNT-1:0][31:0]    r_regs;
    t_lock_state                    r_lock;

    logic [WORD_COUNT-1:0][31:0]    n_regs;
    t_lock_state                    n_lock;
    t_out_beat                      n_out_beat;
    logic                           out_ready;
    logic                           s1_go;
    logic                           in_take;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign s1_go      = r_s1_valid && out_ready;
    assign o_in_stall = r_s1_valid && !out_ready;
    assign in_take    = i_in_valid && !o_in_stall;

    gpsr_access #(
        .WORD_COUNT (WORD_COUNT)
    ) u_access (
        .i_item   (r_s1_beat),
        .i_regs   (r_regs),
        .i_lock   (r_lock),
        .i_bank   (r_bank),
        .o_regs   (n_regs),
        .o_lock   (n_lock),
        .o_result (n_out_beat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_beat <= i_in_beat;
        end
        if (s1_go) begin
            r_out_beat <= n_out_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= '0;
            r_lock <= '{progress: LK_IDLE, engaged: 1'b0};
            for (int i = 0; i < int'(WORD_COUNT); i++) begin
                r_regs[i] <= (i == int'(W_MODE)) ? mode_reset(4'd0) : '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_bank <= i_cfg_wdata;
            end
            if (s1_go) begin
                r_regs <= n_regs;
                r_lock <= n_lock;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall))
        else $error("input stalled while result stage can move");

    a_event_means_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.odr_changed)
            |-> (o_out_beat.new_output != o_out_beat.old_output))
        else $error("pin-change event without output change");

    a_no_event_same_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_beat.odr_changed)
            |-> (o_out_beat.new_output == o_out_beat.old_output))
        else $error("output word differs without pin-change event");

    a_reject_is_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.rejected)
            |-> (!o_out_beat.odr_changed && o_out_beat.read_data == '0))
        else $error("rejected access reported data or event");

    a_lock_needs_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_lock.engaged) |-> (r_lock.progress == LK_DONE))
        else $error("lock engaged without full key sequence");

endmodule

`default_nettype wire

@@ verif/tb_gpio_port_secure_registers.sv @@
// testbench for the gpio port register block: directed and random accesses against a port mirror
`default_nettype none

module tb_gpio_port_secure_registers;
    import gpsr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_BAD = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 150000;
    localparam int unsigned SETTLE_CYCLES = 6;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_WAVE
    } t_stall_style;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    t_in_beat    i_in_beat = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_beat   o_out_beat;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [3:0]  i_cfg_wdata = 4'd0;

    // mirror of the port state
    logic [31:0] regs_mirror [DEF_WORD_COUNT];
    logic [1:0]  lock_step;
    logic        lock_set;
    logic [3:0]  bank_sel;

    t_out_beat   port_results_due [$];
    int unsigned error_count = 0;
    int unsigned beats_sent = 0;
    int unsigned results_checked = 0;
    int unsigned pin_events = 0;
    int unsigned lock_engages = 0;
    int unsigned burst_left = 0;
    int unsigned cycle_count = 0;
    int unsigned rx_tick = 0;
    t_stall_style stall_style = STALL_NONE;

    gpio_port_secure_registers dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_beat   (i_in_beat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     port_results_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] pair_mask(input logic [15:0] pins);
        logic [31:0] m;
        m = '0;
        for (int i = 0; i < 16; i++) begin
            if (pins[i]) m[2*i +: 2] = 2'b11;
        end
        return m;
    endfunction

    function automatic void reload_mirror();
        for (int i = 0; i < DEF_WORD_COUNT; i++) begin
            regs_mirror[i] = '0;
        end
        regs_mirror[W_MODE] = (bank_sel == 4'd0) ? 32'hABFF_FFFF : 32'hFFFF_FFFF;
        lock_set = 1'b0;
    endfunction

    function automatic t_out_beat port_access_result(input t_in_beat b);
        t_out_beat   r;
        logic [31:0] old_out, open_mask, v, m, o, af;
        logic [15:0] pins;
        int unsigned a, w, base;
        logic        chg, done;
        r = '0;
        chg = 1'b0;
        done = 1'b0;
        old_out = regs_mirror[W_OUT];
        open_mask = ~regs_mirror[W_SEC];
        pins = b.secure ? 16'hFFFF : open_mask[15:0];
        w = b.offset >> 2;
        if (b.operation == OP_REINIT) begin
            reload_mirror();
        end else if (b.operation == OP_BAD || b.access_size == 3'd0 || b.access_size > 3'd4
                     || b.offset >= REGISTER_WINDOW) begin
            r.rejected = 1'b1;
        end else if (b.clock_on && b.operation == OP_READ) begin
            v = '0;
            for (int unsigned i = 0; i < b.access_size; i++) begin
                a = b.offset + i;
                if (a < DEF_WORD_COUNT * 4) v[8*i +: 8] = regs_mirror[a >> 2][8*(a & 3) +: 8];
            end
            if (!b.secure) begin
                case (b.offset)
                    OFF_SEC: v = '0;
                    OFF_IN, OFF_OUT, OFF_SETRST, OFF_LOCK, OFF_AFL, OFF_AFH, OFF_RST,
                    OFF_LEVEL, OFF_TYPE: v &= open_mask;
                    OFF_MODE, OFF_SPEED, OFF_PULL: v &= pair_mask(open_mask[15:0]);
                    default: ;
                endcase
            end
            r.read_data = v;
        end else if (b.clock_on) begin
            // non-secure writes skip the security word and only reach open pins of mode, speed, pull, type and af
            if (!b.secure) begin
                if (b.offset == OFF_SEC) begin
                    done = 1'b1;
                end else if (b.offset == OFF_AFL || b.offset == OFF_AFH) begin
                    base = (b.offset == OFF_AFL) ? 0 : 8;
                    m = '0;
                    for (int i = 0; i < 8; i++) begin
                        if (open_mask[base + i]) m[4*i +: 4] = 4'hF;
                    end
                    regs_mirror[w] = (regs_mirror[w] & ~m) | (b.write_data & m);
                    done = 1'b1;
                end else if (b.offset == OFF_MODE || b.offset == OFF_SPEED
                             || b.offset == OFF_PULL) begin
                    m = pair_mask(open_mask[15:0]);
                    regs_mirror[w] = (regs_mirror[w] & ~m) | (b.write_data & m);
                    done = 1'b1;
                end else if (b.offset == OFF_TYPE) begin
                    regs_mirror[w] = (regs_mirror[w] & ~open_mask) | (b.write_data & open_mask);
                    done = 1'b1;
                end
            end
            if (!done) begin
                if (b.offset == OFF_SETRST) begin
                    o = regs_mirror[W_OUT];
                    o |= {16'h0, b.write_data[15:0] & pins};
                    o &= ~{16'h0, b.write_data[31:16] & pins};
                    regs_mirror[W_OUT] = o;
                end else if (b.offset == OFF_RST) begin
                    regs_mirror[W_OUT] &= ~{16'h0, b.write_data[15:0] & pins};
                end else if (b.offset == OFF_LOCK) begin
                    if (!lock_set) begin
                        if (lock_step == LK_IDLE && b.write_data[16]) begin
                            lock_step = LK_ONE;
                        end else if (lock_step == LK_ONE && !b.write_data[16]) begin
                            lock_step = LK_TWO;
                        end else if (lock_step == LK_TWO && b.write_data[16]) begin
                            lock_step = LK_DONE;
                            lock_set = 1'b1;
                            lock_engages++;
                        end else begin
                            lock_step = LK_IDLE;
                        end
                        regs_mirror[W_LOCK] = b.write_data;
                    end
                end else if (b.offset < DEF_WORD_COUNT * 4) begin
                    regs_mirror[w] = b.write_data;
                end
            end
            if ((b.offset == OFF_SETRST || b.offset == OFF_RST || b.offset == OFF_OUT)
                && regs_mirror[W_OUT] != old_out) begin
                regs_mirror[W_IN] = regs_mirror[W_OUT];
                chg = 1'b1;
                pin_events++;
            end
        end
        r.odr_changed = chg;
        r.old_output = old_out;
        r.new_output = chg ? regs_mirror[W_OUT] : old_out;
        r.event_bank = bank_sel;
        r.pin_mode = regs_mirror[W_MODE][2*b.pin +: 2];
        af = b.pin[3] ? regs_mirror[W_AFH] : regs_mirror[W_AFL];
        r.pin_function = af[4*b.pin[2:0] +: 4];
        return r;
    endfunction

    function automatic t_in_beat make_access(input logic [1:0] op, input logic [11:0] off,
                                             input logic [2:0] size, input logic [31:0] data,
                                             input logic sec, input logic clk_on,
                                             input logic [3:0] pin);
        t_in_beat b;
        b.operation = op;
        b.offset = off;
        b.access_size = size;
        b.write_data = data;
        b.secure = sec;
        b.clock_on = clk_on;
        b.pin = pin;
        return b;
    endfunction

    function automatic t_in_beat random_access();
        t_in_beat    b;
        int unsigned r;
        b.write_data = $urandom;
        b.secure = ($urandom_range(0, 9) < 7);
        b.clock_on = ($urandom_range(0, 9) != 0);
        b.pin = 4'($urandom_range(0, 15));
        r = $urandom_range(0, 99);
        if (r < 3) b.operation = OP_REINIT;
        else if (r < 5) b.operation = OP_BAD;
        else if (r < 50) b.operation = OP_READ;
        else b.operation = OP_WRITE;
        r = $urandom_range(0, 99);
        if (r < 70) b.offset = 12'($urandom_range(0, DEF_WORD_COUNT - 1) * 4);
        else if (r < 85) b.offset = 12'($urandom_range(0, 63));
        else if (r < 93) b.offset = 12'($urandom_range(64, REGISTER_WINDOW - 1));
        else b.offset = 12'($urandom_range(REGISTER_WINDOW, 4095));
        r = $urandom_range(0, 99);
        if (r < 85) b.access_size = 3'd4;
        else if (r < 95) b.access_size = 3'($urandom_range(1, 3));
        else b.access_size = 3'($urandom_range(0, 7));
        return b;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s on result %0d, got %h, want %h", what, results_checked, got, want);
        error_count++;
    endtask

    // result side: compare each beat taken and drive its own stall pattern
    always @(posedge i_clk) begin : rx_side
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (port_results_due.size() == 0) begin
                report_mismatch("result with none pending", o_out_beat.read_data, '0);
            end else begin
                want = port_results_due.pop_front();
                if (o_out_beat.rejected !== want.rejected)
                    report_mismatch("rejected", 32'(o_out_beat.rejected),
                                    32'(want.rejected));
                if (o_out_beat.read_data !== want.read_data)
                    report_mismatch("read_data", o_out_beat.read_data, want.read_data);
                if (o_out_beat.odr_changed !== want.odr_changed)
                    report_mismatch("odr_changed", 32'(o_out_beat.odr_changed),
                                    32'(want.odr_changed));
                if (o_out_beat.old_output !== want.old_output)
                    report_mismatch("old_output", o_out_beat.old_output, want.old_output);
                if (o_out_beat.new_output !== want.new_output)
                    report_mismatch("new_output", o_out_beat.new_output, want.new_output);
                if (o_out_beat.event_bank !== want.event_bank)
                    report_mismatch("event_bank", 32'(o_out_beat.event_bank),
                                    32'(want.event_bank));
                if (o_out_beat.pin_mode !== want.pin_mode)
                    report_mismatch("pin_mode", 32'(o_out_beat.pin_mode),
                                    32'(want.pin_mode));
                if (o_out_beat.pin_function !== want.pin_function)
                    report_mismatch("pin_function", 32'(o_out_beat.pin_function),
                                    32'(want.pin_function));
                results_checked++;
            end
        end
        rx_tick++;
        if (rx_tick % 97 == 0) stall_style = t_stall_style'($urandom_range(0, 3));
        case (stall_style)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:     i_out_stall <= rx_tick[3];
        endcase
    end

    task automatic send_access(input t_in_beat b);
        int unsigned gap;
        i_in_valid <= 1'b1;
        i_in_beat <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        port_results_due.push_back(port_access_result(b));
        beats_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 10);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (port_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_bank(input logic [3:0] bank);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= bank;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        bank_sel = bank;
    endtask

    task automatic test_refused_accesses();
        send_access(make_access(OP_BAD, OFF_MODE, 3'd4, 32'h0, 1'b1, 1'b1, 4'd0));
        send_access(make_access(OP_READ, OFF_MODE, 3'd0, 32'h0, 1'b1, 1'b1, 4'd1));
        send_access(make_access(OP_WRITE, OFF_OUT, 3'd7, 32'hFFFF_FFFF, 1'b1, 1'b1, 4'd15));
        send_access(make_access(OP_READ, 12'hFFF, 3'd4, 32'h0, 1'b0, 1'b1, 4'd8));
    endtask

    task automatic test_gated_clock();
        send_access(make_access(OP_WRITE, OFF_OUT, 3'd4, 32'hFFFF_FFFF, 1'b1, 1'b0, 4'd2));
        send_access(make_access(OP_READ, OFF_MODE, 3'd4, 32'h0, 1'b1, 1'b0, 4'd3));
    endtask

    task automatic test_output_word();
        send_access(make_access(OP_READ, OFF_MODE, 3'd4, 32'h0, 1'b1, 1'b1, 4'd15));
        send_access(make_access(OP_WRITE, OFF_OUT, 3'd4, 32'h1234_5678, 1'b1, 1'b1, 4'd4));
        send_access(make_access(OP_WRITE, OFF_SETRST, 3'd4, 32'h00F0_000F, 1'b1, 1'b1, 4'd5));
        send_access(make_access(OP_WRITE, OFF_RST, 3'd4, 32'h0000_FFFF, 1'b1, 1'b1, 4'd6));
    endtask

    task automatic test_secure_pins();
        send_access(make_access(OP_WRITE, OFF_SEC, 3'd4, 32'h0000_00FF, 1'b1, 1'b1, 4'd7));
        send_access(make_access(OP_READ, OFF_OUT, 3'd4, 32'h0, 1'b0, 1'b1, 4'd8));
        send_access(make_access(OP_READ, OFF_MODE, 3'd4, 32'h0, 1'b0, 1'b1, 4'd9));
        send_access(make_access(OP_READ, OFF_SEC, 3'd4, 32'h0, 1'b0, 1'b1, 4'd10));
        send_access(make_access(OP_WRITE, OFF_AFH, 3'd4, 32'hFFFF_FFFF, 1'b0, 1'b1, 4'd9));
        send_access(make_access(OP_WRITE, OFF_SETRST, 3'd4, 32'h0000_FFFF, 1'b0, 1'b1, 4'd11));
        send_access(make_access(OP_WRITE, OFF_SEC, 3'd4, 32'h0, 1'b0, 1'b1, 4'd12));
    endtask

    task automatic test_lock_key();
        send_access(make_access(OP_WRITE, OFF_LOCK, 3'd4, 32'h0001_0000, 1'b1, 1'b1, 4'd13));
        send_access(make_access(OP_WRITE, OFF_LOCK, 3'd4, 32'h0000_00AA, 1'b1, 1'b1, 4'd14));
        send_access(make_access(OP_WRITE, OFF_LOCK, 3'd4, 32'h0001_0055, 1'b1, 1'b1, 4'd15));
        send_access(make_access(OP_WRITE, OFF_LOCK, 3'd4, 32'h0000_0000, 1'b1, 1'b1, 4'd0));
        send_access(make_access(OP_READ, OFF_LOCK, 3'd4, 32'h0, 1'b1, 1'b1, 4'd1));
    endtask

    task automatic test_narrow_and_gap();
        // narrow read inside the last word, read in the unused window, unaligned byte write
        send_access(make_access(OP_READ, 12'h031, 3'd3, 32'h0, 1'b1, 1'b1, 4'd2));
        send_access(make_access(OP_READ, 12'h100, 3'd4, 32'h0, 1'b0, 1'b1, 4'd3));
        send_access(make_access(OP_WRITE, 12'h015, 3'd1, 32'hA5A5_A5A5, 1'b1, 1'b1, 4'd4));
    endtask

    task automatic test_bank_reinit();
        set_bank(4'd15);
        send_access(make_access(OP_REINIT, 12'hFFF, 3'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 4'd15));
    endtask

    task automatic test_random_traffic();
        int unsigned n;
        t_in_beat    b;
        for (int ph = 0; ph < 4; ph++) begin
            set_bank(ph == 0 ? 4'd0 : ph == 2 ? 4'd15 : 4'($urandom_range(1, 14)));
            send_access(make_access(OP_REINIT, 12'h0, 3'd4, 32'h0, 1'b1, 1'b1,
                                    4'($urandom_range(0, 15))));
            n = 0;
            while (n < 100) begin
                if ($urandom_range(0, 19) == 0) begin
                    // well-formed lock key run with random payload bits
                    for (int k = 0; k < 3; k++) begin
                        b = make_access(OP_WRITE, OFF_LOCK, 3'd4, $urandom,
                                        1'($urandom_range(0, 1)),
                                        1'b1, 4'($urandom_range(0, 15)));
                        b.write_data[16] = (k != 1);
                        send_access(b);
                    end
                    n += 3;
                end else begin
                    send_access(random_access());
                    n++;
                end
            end
        end
    endtask

    initial begin
        bank_sel = 4'd0;
        lock_step = LK_IDLE;
        reload_mirror();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_refused_accesses();
        test_gated_clock();
        test_output_word();
        test_secure_pins();
        test_lock_key();
        test_narrow_and_gap();
        test_bank_reinit();
        test_random_traffic();
        settle();
        $display("%0d accesses checked in %0d results, %0d pin-change events, %0d lock engages",
                 beats_sent, results_checked, pin_events, lock_engages);
        $display("ports 0 and 15 plus two random ports, %0d mismatches", error_count);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
